### rtl/core/spimbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spimbw_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int CNT_W         = $clog2(BITS_PER_BYTE + 1);
	localparam int IDX_W         = $clog2(BITS_PER_BYTE);
	localparam logic [7:0]  MAX_BIT_COUNT = 8'd248;
	localparam logic [15:0] MIN_QUANTUM   = 16'd50;

	// register indexes
	localparam logic [1:0] REG_CLOCK_PHASE    = 2'd0;
	localparam logic [1:0] REG_CLOCK_POLARITY = 2'd1;
	localparam logic [1:0] REG_QUANTUM_US     = 2'd2;

	// program steps
	localparam logic [1:0] PC_SEG_LEAD  = 2'd0;
	localparam logic [1:0] PC_SEG_MID   = 2'd1;
	localparam logic [1:0] PC_SEG_TRAIL = 2'd2;
	localparam logic [1:0] PC_SEG_END   = 2'd3;

	// mosi source
	localparam logic [1:0] MOSI_BIT   = 2'd0;
	localparam logic [1:0] MOSI_PHASE = 2'd1;
	localparam logic [1:0] MOSI_ZERO  = 2'd2;

	// sck source
	localparam logic [1:0] SCK_IDLE   = 2'd0;
	localparam logic [1:0] SCK_ACTIVE = 2'd1;
	localparam logic [1:0] SCK_PHASE  = 2'd2;

	// hold source
	localparam logic [1:0] HOLD_ZERO = 2'd0;
	localparam logic [1:0] HOLD_ONE  = 2'd1;
	localparam logic [1:0] HOLD_TWO  = 2'd2;

	typedef struct packed {
		logic [1:0] mosi_sel;
		logic [1:0] sck_sel;
		logic [1:0] hold_sel;
		logic       set_cur;   // latch the sent bit as present mosi level
		logic       shift;     // move to next bit, count it off
		logic       branch;    // jump to branch_pc while bits remain in byte
		logic       finish;    // last step of the byte
		logic [1:0] next_pc;
		logic [1:0] branch_pc;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode_rom(input logic [1:0] pc);
		ctrl_word_t w;
		w = '0;
		unique case (pc)
			PC_SEG_LEAD: begin
				w.mosi_sel = MOSI_PHASE;
				w.sck_sel  = SCK_PHASE;
				w.hold_sel = HOLD_ONE;
				w.next_pc  = PC_SEG_MID;
			end
			PC_SEG_MID: begin
				w.mosi_sel = MOSI_BIT;
				w.sck_sel  = SCK_ACTIVE;
				w.hold_sel = HOLD_TWO;
				w.set_cur  = 1'b1;
				w.next_pc  = PC_SEG_TRAIL;
			end
			PC_SEG_TRAIL: begin
				w.mosi_sel  = MOSI_BIT;
				w.sck_sel   = SCK_IDLE;
				w.hold_sel  = HOLD_ONE;
				w.shift     = 1'b1;
				w.branch    = 1'b1;
				w.next_pc   = PC_SEG_END;
				w.branch_pc = PC_SEG_LEAD;
			end
			PC_SEG_END: begin
				w.mosi_sel = MOSI_ZERO;
				w.sck_sel  = SCK_IDLE;
				w.hold_sel = HOLD_ZERO;
				w.finish   = 1'b1;
				w.next_pc  = PC_SEG_LEAD;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/core/spi_master_bit_window_tx_core.sv
`timescale 1ns / 1ps
`default_nettype none

// transmit-only spi master, pin timeline generator
// input channel (in_valid / in_stall): one byte per transfer; the first byte
//   of a window, taken while idle, also brings start_bit and bit_count
// output channel (out_valid / out_stall): one pin segment per transfer,
//   mosi and sck levels with a hold time of zero, one or two quanta
// each sent bit gives three segments, ordered by clock phase and polarity;
//   every byte closes with a mosi-low segment flagged byte_last, and
//   transfer_done marks the segment that ends the whole window
// config port (cfg_valid / cfg_ready): always ready; the user must write it
//   only while idle, which the block itself does not enforce
// timing: the microcode sequencer emits one segment per cycle into the
//   output register unless stalled, starting after the byte is latched
// a new byte is accepted once the sequencer has issued the end segment of
//   the previous one, even while that segment still waits at the output
// receiver stall freezes the sequencer; the held segment stays unchanged
// reset: idle, no bits pending, mosi level low, phase 0, polarity 0,
//   quantum 50 us; no output pending
module spi_master_bit_window_tx_core
	import spimbw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [2:0]  start_bit,
	input  wire logic [7:0]  bit_count,
	// segment output
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             mosi_level,
	output logic             sck_level,
	output logic [16:0]      hold_us,
	output logic             byte_last,
	output logic             transfer_done,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration registers
	logic        phase_q;
	logic        polarity_q;
	logic [15:0] quantum_q;

	// sequencer state
	logic                     busy_q;
	logic [1:0]               pc_q;
	logic [CNT_W-1:0]         cnt_q;      // bits left in this byte
	logic [BITS_PER_BYTE-1:0] data_q;     // msb is the bit being sent
	logic [7:0]               rem_q;      // bits left in the window
	logic                     mosi_cur_q;

	// output register
	logic        out_valid_q;
	logic        mosi_q;
	logic        sck_q;
	logic [16:0] hold_q;
	logic        last_q;
	logic        done_q;

	ctrl_word_t  cw;
	logic        in_fire;
	logic        out_free;
	logic        step;
	logic [IDX_W-1:0] first;
	logic [7:0]  req;
	logic [7:0]  window;
	logic [CNT_W-1:0] span;
	logic [CNT_W-1:0] count;
	logic [15:0] q_eff;
	logic        bit_now;
	logic        idle_lvl;
	logic        seg_mosi;
	logic        seg_sck;
	logic [16:0] seg_hold;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign in_fire   = in_valid && !busy_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign step      = busy_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			polarity_q <= 1'b0;
			quantum_q  <= MIN_QUANTUM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLOCK_PHASE:    phase_q    <= cfg_data[0];
				REG_CLOCK_POLARITY: polarity_q <= cfg_data[0];
				REG_QUANTUM_US:     quantum_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// window set-up for the incoming byte
	always_comb begin
		if (rem_q == 8'd0) begin
			first  = start_bit;
			req    = (bit_count > MAX_BIT_COUNT) ? MAX_BIT_COUNT : bit_count;
		end else begin
			first  = '0;
			req    = rem_q;
		end
		window = 8'(BITS_PER_BYTE) - 8'(first);
		span   = CNT_W'(window);
		count  = (req < window) ? CNT_W'(req) : span;
	end

	// microcode datapath
	assign cw       = ucode_rom(pc_q);
	assign q_eff    = (quantum_q < MIN_QUANTUM) ? MIN_QUANTUM : quantum_q;
	assign bit_now  = data_q[BITS_PER_BYTE-1];
	assign idle_lvl = polarity_q;

	always_comb begin
		unique case (cw.mosi_sel)
			MOSI_BIT:   seg_mosi = bit_now;
			MOSI_PHASE: seg_mosi = phase_q ? mosi_cur_q : bit_now;
			default:    seg_mosi = 1'b0;
		endcase
		unique case (cw.sck_sel)
			SCK_IDLE:   seg_sck = idle_lvl;
			SCK_ACTIVE: seg_sck = !idle_lvl;
			default:    seg_sck = phase_q ? !idle_lvl : idle_lvl;
		endcase
		unique case (cw.hold_sel)
			HOLD_ONE: seg_hold = {1'b0, q_eff};
			HOLD_TWO: seg_hold = {q_eff, 1'b0};
			default:  seg_hold = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= PC_SEG_LEAD;
			cnt_q      <= '0;
			rem_q      <= '0;
			mosi_cur_q <= 1'b0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
			cnt_q  <= count;
			rem_q  <= req - 8'(count);
			pc_q   <= (count == '0) ? PC_SEG_END : PC_SEG_LEAD;
		end else if (step) begin
			if (cw.set_cur) begin
				mosi_cur_q <= bit_now;
			end
			if (cw.shift) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cw.finish) begin
				busy_q     <= 1'b0;
				mosi_cur_q <= 1'b0;
			end
			// branch back while this byte still has bits after the current one
			if (cw.branch && cnt_q != CNT_W'(1)) begin
				pc_q <= cw.branch_pc;
			end else begin
				pc_q <= cw.next_pc;
			end
		end
	end

	// byte shifter, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= data_byte << first;
		end else if (step && cw.shift) begin
			data_q <= data_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mosi_q <= seg_mosi;
			sck_q  <= seg_sck;
			hold_q <= seg_hold;
			last_q <= cw.finish;
			done_q <= cw.finish && (rem_q == 8'd0);
		end
	end

	assign out_valid     = out_valid_q;
	assign mosi_level    = mosi_q;
	assign sck_level     = sck_q;
	assign hold_us       = hold_q;
	assign byte_last     = last_q;
	assign transfer_done = done_q;

	// a bit step always has a bit left to send
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && pc_q != PC_SEG_END |-> cnt_q != '0)
		else $error("bit step with empty byte count");

	// window count never exceeds the clamp
	a_rem_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= MAX_BIT_COUNT)
		else $error("remaining bits above clamp");

	// end of window is always the end of a byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> last_q)
		else $error("transfer done without byte last");

	// an accepted byte starts the sequencer
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy_q)
		else $error("sequencer not started after byte transfer");

endmodule

`default_nettype wire

### bench/spimbw_segment_checker.sv
`timescale 1ns / 1ps

module spimbw_segment_checker
	import spimbw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [2:0]  start_bit,
	input  wire logic [7:0]  bit_count,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        mosi_level,
	input  wire logic        sck_level,
	input  wire logic [16:0] hold_us,
	input  wire logic        byte_last,
	input  wire logic        transfer_done,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic        mosi;
		logic        sck;
		logic [16:0] hold;
		logic        last;
		logic        done;
	} pin_seg_t;

	pin_seg_t    seg_q[$];
	logic        cpha_reg;
	logic        cpol_reg;
	logic [15:0] quantum_reg;
	logic [7:0]  bits_left;
	logic        mosi_now;
	int          mismatches;
	int          seg_no;

	assign fail_count = mismatches;

	function automatic void push_seg(input logic m, input logic s, input logic [16:0] h,
			input logic l, input logic d);
		pin_seg_t e;
		e.mosi = m;
		e.sck  = s;
		e.hold = h;
		e.last = l;
		e.done = d;
		seg_q.push_back(e);
	endfunction

	// pin segments that one byte causes
	function automatic void predict_segments(input logic [7:0] d, input logic [2:0] s,
			input logic [7:0] c);
		logic [15:0] qv;
		logic [16:0] one_q;
		logic [16:0] two_q;
		logic        idle_lvl;
		logic        act_lvl;
		logic        b;
		int          first;
		int          nbits;
		int          idx;
		qv       = (quantum_reg < MIN_QUANTUM) ? MIN_QUANTUM : quantum_reg;
		one_q    = {1'b0, qv};
		two_q    = {qv, 1'b0};
		idle_lvl = cpol_reg;
		act_lvl  = ~cpol_reg;
		first    = 0;
		if (bits_left == 8'd0) begin
			first     = s;
			bits_left = (c > MAX_BIT_COUNT) ? MAX_BIT_COUNT : c;
		end
		nbits = BITS_PER_BYTE - first;
		if (nbits > bits_left)
			nbits = bits_left;
		for (int i = 0; i < nbits; i++) begin
			idx = first + i;
			b   = d[7 - idx];
			if (!cpha_reg)
				push_seg(b, idle_lvl, one_q, 1'b0, 1'b0);
			else
				push_seg(mosi_now, act_lvl, one_q, 1'b0, 1'b0);
			mosi_now = b;
			push_seg(b, act_lvl, two_q, 1'b0, 1'b0);
			push_seg(b, idle_lvl, one_q, 1'b0, 1'b0);
		end
		bits_left = bits_left - 8'(nbits);
		mosi_now  = 1'b0;
		push_seg(1'b0, idle_lvl, 17'd0, 1'b1, bits_left == 8'd0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pin_seg_t want;
		if (!arst_n) begin
			cpha_reg    = 1'b0;
			cpol_reg    = 1'b0;
			quantum_reg = MIN_QUANTUM;
			bits_left   = 8'd0;
			mosi_now    = 1'b0;
			mismatches  = 0;
			seg_no      = 0;
			seg_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CLOCK_PHASE:    cpha_reg    = cfg_data[0];
					REG_CLOCK_POLARITY: cpol_reg    = cfg_data[0];
					REG_QUANTUM_US:     quantum_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_segments(data_byte, start_bit, bit_count);
			if (out_valid && !out_stall) begin
				if (seg_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("segment %0d: none expected,", seg_no);
						$display(" got mosi %b sck %b hold %0d last %b done %b",
							mosi_level, sck_level, hold_us, byte_last,
							transfer_done);
					end
				end else begin
					want = seg_q.pop_front();
					if (want.mosi !== mosi_level || want.sck !== sck_level ||
							want.hold !== hold_us || want.last !== byte_last ||
							want.done !== transfer_done) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("segment %0d: expected mosi %b sck %b ",
								seg_no, want.mosi, want.sck);
							$write("hold %0d last %b done %b,",
								want.hold, want.last, want.done);
							$display(" got mosi %b sck %b hold %0d last %b done %b",
								mosi_level, sck_level, hold_us, byte_last,
								transfer_done);
						end
					end
				end
				seg_no++;
			end
			pending <= seg_q.size();
		end
	end

endmodule

### bench/tb_spi_master_bit_window_tx_core.sv
`timescale 1ns / 1ps

module tb_spi_master_bit_window_tx_core;
	import spimbw_pkg::*;

	// index with no register behind it, writes there must change nothing
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_BYTES = 420;
	localparam int SETTLE       = 32;
	localparam int LIMIT        = 1500000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic [2:0]  start_bit;
	logic [7:0]  bit_count;
	logic        out_valid;
	logic        out_stall;
	logic        mosi_level;
	logic        sck_level;
	logic [16:0] hold_us;
	logic        byte_last;
	logic        transfer_done;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int   fail_count;
	int   pending;
	int   bytes_sent;
	int   cycles;
	// calm stretch: no gaps on the input, no stalls on the output
	logic calm;

	spi_master_bit_window_tx_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_bit     (start_bit),
		.bit_count     (bit_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mosi_level    (mosi_level),
		.sck_level     (sck_level),
		.hold_us       (hold_us),
		.byte_last     (byte_last),
		.transfer_done (transfer_done),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	spimbw_segment_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_bit     (start_bit),
		.bit_count     (bit_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mosi_level    (mosi_level),
		.sck_level     (sck_level),
		.hold_us       (hold_us),
		.byte_last     (byte_last),
		.transfer_done (transfer_done),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, generous against the slowest legal run
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("spi_master_bit_window_tx_core: mismatch");
		$finish;
	end

	// output side: a fresh stall length for every segment transfer
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = calm ? 0 : $urandom_range(0, 17);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// one byte transfer; valid is left high so back-to-back bytes need no drop
	task automatic send_byte(input logic [7:0] d, input logic [2:0] s, input logic [7:0] c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		start_bit <= s;
		bit_count <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	// a whole bit window: the first byte brings start and count, the rest carry
	// random junk in those fields, which the block must ignore mid-window
	task automatic run_window(input logic [2:0] s, input logic [7:0] c,
			input logic [23:0] lead, input int nlead);
		int         left;
		int         take;
		int         j;
		logic [7:0] d;
		left = (c > MAX_BIT_COUNT) ? MAX_BIT_COUNT : c;
		take = BITS_PER_BYTE - s;
		if (take > left)
			take = left;
		d = (nlead > 0) ? lead[23:16] : 8'($urandom_range(0, 255));
		send_byte(d, s, c);
		left = left - take;
		j = 1;
		while (left > 0) begin
			d = (j < nlead) ? lead[23 - 8 * j -: 8] : 8'($urandom_range(0, 255));
			send_byte(d, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			take = (left > BITS_PER_BYTE) ? BITS_PER_BYTE : left;
			left = left - take;
			j++;
		end
	endtask

	// stop feeding, wait for the last segment and let the sequencer settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// only bit 0 counts for phase and polarity, upper bits get junk
	task automatic write_settings(input logic ph, input logic pol, input logic [15:0] q);
		logic [14:0] junk;
		junk = 15'($urandom_range(0, 32767));
		write_reg(REG_CLOCK_PHASE, {junk, ph});
		junk = 15'($urandom_range(0, 32767));
		write_reg(REG_CLOCK_POLARITY, {junk, pol});
		if ($urandom_range(0, 1) == 1)
			write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
		write_reg(REG_QUANTUM_US, q);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          phase_no;
		int          phase_start;
		int          phase_goal;
		int          directed_bytes;
		int          r;
		logic [2:0]  s;
		logic [7:0]  c;
		logic [15:0] q;
		in_valid   = 1'b0;
		data_byte  = 8'd0;
		start_bit  = 3'd0;
		bit_count  = 8'd0;
		cfg_valid  = 1'b0;
		cfg_index  = 2'd0;
		cfg_data   = 16'd0;
		arst_n     = 1'b0;
		calm       = 1'b0;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: phase 0, polarity 0, 50 us quantum
		run_window(3'd0, 8'd8, 24'hA50000, 1);
		run_window(3'd7, 8'd1, 24'h010000, 1);
		// zero count: only the mosi-low segment, window closed at once
		run_window(3'd3, 8'd0, 24'hFF0000, 1);
		// window across three bytes, starting mid-byte
		run_window(3'd5, 8'd12, 24'h3CFF80, 3);
		drain();

		// quantum below the minimum, both modes high
		write_settings(1'b1, 1'b1, 16'd0);
		run_window(3'd0, 8'd8, 24'h000000, 1);
		run_window(3'd0, 8'd8, 24'hFF0000, 1);
		run_window(3'd4, 8'd2, 24'h0A0000, 1);
		drain();

		write_settings(1'b1, 1'b0, 16'd49);
		run_window(3'd0, 8'd16, 24'h55AA00, 2);
		run_window(3'd6, 8'd3, 24'h02FF00, 2);
		drain();

		// largest quantum, two quanta fill the whole hold field
		write_settings(1'b0, 1'b1, 16'hFFFF);
		run_window(3'd1, 8'd7, 24'h7F0000, 1);
		run_window(3'd2, 8'd0, 24'h000000, 1);
		run_window(3'd0, 8'd9, 24'h80FF00, 2);
		drain();
		directed_bytes = bytes_sent;

		// random phases, each under its own settings
		phase_no = 0;
		while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
			case ($urandom_range(0, 7))
				0:       q = 16'd0;
				1:       q = 16'd49;
				2:       q = 16'd50;
				3:       q = 16'd51;
				4:       q = 16'hFFFF;
				5:       q = 16'($urandom_range(0, 65535));
				default: q = 16'($urandom_range(50, 400));
			endcase
			// first four phases walk every phase and polarity pairing
			if (phase_no < 4)
				write_settings(phase_no[0], phase_no[1], q);
			else
				write_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), q);
			calm        = ($urandom_range(0, 3) == 0);
			phase_goal  = $urandom_range(20, 60);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < phase_goal &&
					bytes_sent - directed_bytes < RANDOM_BYTES) begin
				s = 3'($urandom_range(0, 7));
				r = $urandom_range(0, 39);
				// mostly short windows, a few long or out of range
				if (r == 0)
					c = 8'd0;
				else if (r == 1)
					c = 8'($urandom_range(249, 255));
				else if (r == 2)
					c = 8'($urandom_range(25, 248));
				else
					c = 8'($urandom_range(1, 24));
				run_window(s, c, 24'd0, 0);
			end
			drain();
			calm = 1'b0;
			phase_no++;
		end

		if (fail_count == 0)
			$display("spi_master_bit_window_tx_core: match");
		else
			$display("spi_master_bit_window_tx_core: mismatch");
		$finish;
	end

endmodule

### files.f
rtl/core/spimbw_pkg.sv
rtl/core/spi_master_bit_window_tx_core.sv
bench/spimbw_segment_checker.sv
bench/tb_spi_master_bit_window_tx_core.sv
